### rtl/hngm_pkg.sv
// package for the hashed name grid map
// sizes, codes and record types shared by the rtl; no dependencies
package hngm_pkg;

  localparam int SLOTS         = 16;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int NAME_BYTES    = 16;
  localparam int NAME_MAX      = NAME_BYTES - 1;
  localparam int NAME_W        = 8 * NAME_MAX;
  localparam int LO_W          = 64;
  localparam int HI_W          = 56;
  localparam int LEN_W         = 4;
  localparam int MAX_SIDE      = 16;
  localparam int SIDE_W        = $clog2(MAX_SIDE);
  localparam int CELL_W        = 2 * SIDE_W;
  localparam int KIND_BITS     = 4;
  localparam int CFG_W         = 5;
  localparam int CRC_W         = 32;
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

  typedef enum logic [2:0] {
    FN_PUT     = 3'd0,
    FN_KIND    = 3'd1,
    FN_PRESENT = 3'd2,
    FN_READ    = 3'd3,
    FN_PREFIX  = 3'd4,
    FN_CLEAR   = 3'd5
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_BOUNDS   = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [NAME_W-1:0] name;
  } key_t;

  typedef struct packed {
    logic                 present;
    logic [KIND_BITS-1:0] kind;
  } cell_t;

  // byte mask covering the first len bytes of a name
  function automatic logic [NAME_W-1:0] name_mask(input logic [LEN_W-1:0] len);
    logic [NAME_W-1:0] m;
    m = '0;
    for (int b = 0; b < NAME_MAX; b++) begin
      if (b < int'(len)) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  // one reflected crc-32 byte step
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                input logic [7:0] d);
    logic [CRC_W-1:0] c;
    c = c_in ^ {{(CRC_W-8){1'b0}}, d};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

### rtl/hashed_name_grid_map.sv
// hashed name grid map top level
// key and cell memories with a sequencer for hash, probe, clear and scan; uses hngm_pkg
//
// One item is handled at a time. A name is hashed one byte per cycle, then the table is
// probed linearly, a read state and a compare state per used slot, through the key memory's
// registered read port. A put of a new name then clears that slot's 256-cell grid, one
// cell per cycle through the single write port of the cell memory. Cell access adds a
// read and a write state, prefix-any scans every slot up to the first hit with a read
// and a compare state per used slot and only a read state per unused slot, and clear
// resets all slot-used bits at once. Slot-used bits are flip-flops cleared by reset,
// so there is no clearing pass after reset. The next item is taken while a finished
// result still waits in the output register.
module hashed_name_grid_map (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_idx_i,
  input  logic [hngm_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          in_func_i,
  input  logic [hngm_pkg::LO_W-1:0]           in_name_lo_i,
  input  logic [hngm_pkg::HI_W-1:0]           in_name_hi_i,
  input  logic [hngm_pkg::LEN_W-1:0]          in_name_len_i,
  input  logic signed [15:0]                  in_col_i,
  input  logic signed [15:0]                  in_row_i,
  input  logic [3:0]                          in_kind_value_i,
  input  logic                                in_present_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [1:0]                          out_status_o,
  output logic [3:0]                          out_slot_o,
  output logic                                out_inserted_o,
  output logic                                out_answer_o
);

  localparam int CELL_AW = hngm_pkg::SLOT_W + hngm_pkg::CELL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CRC, S_PRB_RD, S_PRB_CMP, S_CLR,
    S_CELL_RD, S_CELL_WR, S_SCAN_RD, S_SCAN_CMP, S_DONE
  } state_e;

  state_e                          state_q;
  hngm_pkg::func_e                 func_q;
  logic [hngm_pkg::NAME_W-1:0]     name_q;
  logic [hngm_pkg::LEN_W-1:0]      len_q;
  logic [hngm_pkg::CELL_W-1:0]     cell_q;
  logic [hngm_pkg::KIND_BITS-1:0]  kind_q;
  logic                            pres_q;
  logic [hngm_pkg::CRC_W-1:0]      crc_q;
  logic [hngm_pkg::LEN_W-1:0]      byte_q;
  logic [hngm_pkg::SLOT_W-1:0]     base_q;
  logic [hngm_pkg::SLOT_W-1:0]     cnt_q;
  logic [hngm_pkg::CELL_W-1:0]     sweep_q;
  logic [hngm_pkg::SLOT_W-1:0]     slot_q;
  hngm_pkg::status_e               status_q;
  logic                            ins_q;
  logic                            ans_q;
  logic [hngm_pkg::SLOTS-1:0]      used_q;
  logic [hngm_pkg::CFG_W-1:0]      width_q;
  logic [hngm_pkg::CFG_W-1:0]      height_q;
  logic                            out_valid_q;
  logic [1:0]                      out_status_q;
  logic [3:0]                      out_slot_q;
  logic                            out_ins_q;
  logic                            out_ans_q;

  // memories
  hngm_pkg::key_t  key_mem [hngm_pkg::SLOTS];
  hngm_pkg::cell_t cell_mem [2**CELL_AW];
  hngm_pkg::key_t  key_rd_q;
  hngm_pkg::cell_t cell_rd_q;

  logic                         key_we;
  logic [hngm_pkg::SLOT_W-1:0]  key_addr;
  hngm_pkg::key_t               key_wd;
  logic                         cell_we;
  logic [CELL_AW-1:0]           cell_addr;
  hngm_pkg::cell_t              cell_wd;

  logic [hngm_pkg::CFG_W-1:0]   w_eff, h_eff;
  logic [hngm_pkg::LEN_W-1:0]   len_c;
  logic [hngm_pkg::NAME_W-1:0]  name_c;
  logic                         inb_c;
  logic [hngm_pkg::CELL_W-1:0]  cell_c;
  logic [hngm_pkg::SLOT_W-1:0]  probe_s;
  logic [hngm_pkg::NAME_W-1:0]  mask_q;
  logic                         key_match;
  logic                         pfx_hit;
  logic                         out_free;
  logic [hngm_pkg::CRC_W-1:0]   crc_fin;

  assign w_eff = (width_q > hngm_pkg::CFG_W'(hngm_pkg::MAX_SIDE))
                 ? hngm_pkg::CFG_W'(hngm_pkg::MAX_SIDE) : width_q;
  assign h_eff = (height_q > hngm_pkg::CFG_W'(hngm_pkg::MAX_SIDE))
                 ? hngm_pkg::CFG_W'(hngm_pkg::MAX_SIDE) : height_q;

  assign len_c  = (in_name_len_i > hngm_pkg::LEN_W'(hngm_pkg::NAME_MAX))
                  ? hngm_pkg::LEN_W'(hngm_pkg::NAME_MAX) : in_name_len_i;
  assign name_c = {in_name_hi_i, in_name_lo_i} & hngm_pkg::name_mask(len_c);
  assign inb_c  = !in_col_i[15] && (16'(in_col_i) < 16'(w_eff)) &&
                  !in_row_i[15] && (16'(in_row_i) < 16'(h_eff));
  assign cell_c = hngm_pkg::CELL_W'(in_row_i[hngm_pkg::SIDE_W-1:0]) *
                  hngm_pkg::CELL_W'(w_eff) +
                  hngm_pkg::CELL_W'(in_col_i[hngm_pkg::SIDE_W-1:0]);

  assign probe_s   = base_q + cnt_q;
  assign mask_q    = hngm_pkg::name_mask(len_q);
  assign key_match = (key_rd_q.len == len_q) && (key_rd_q.name == name_q);
  assign pfx_hit   = (key_rd_q.len >= len_q) && ((key_rd_q.name & mask_q) == name_q) &&
                     cell_rd_q.present;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign crc_fin   = ~crc_q;

  // memory port control
  always_comb begin
    key_we    = 1'b0;
    key_addr  = probe_s;
    key_wd    = '{len: len_q, name: name_q};
    cell_we   = 1'b0;
    cell_addr = {slot_q, cell_q};
    cell_wd   = cell_rd_q;
    case (state_q)
      S_PRB_RD: key_we = !used_q[probe_s] && (func_q == hngm_pkg::FN_PUT);
      S_CLR: begin
        cell_we   = 1'b1;
        cell_addr = {slot_q, sweep_q};
        cell_wd   = '0;
      end
      S_CELL_WR: begin
        cell_we = (func_q == hngm_pkg::FN_KIND) || (func_q == hngm_pkg::FN_PRESENT);
        if (func_q == hngm_pkg::FN_KIND) cell_wd.kind = kind_q;
        else cell_wd.present = pres_q;
      end
      S_SCAN_RD: begin
        key_addr  = cnt_q;
        cell_addr = {cnt_q, cell_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) key_mem[key_addr] <= key_wd;
    key_rd_q <= key_mem[key_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[cell_addr] <= cell_wd;
    cell_rd_q <= cell_mem[cell_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      used_q       <= '0;
      width_q      <= hngm_pkg::CFG_W'(hngm_pkg::MAX_SIDE);
      height_q     <= hngm_pkg::CFG_W'(hngm_pkg::MAX_SIDE);
      out_valid_q  <= 1'b0;
      out_status_q <= '0;
      out_slot_q   <= '0;
      out_ins_q    <= 1'b0;
      out_ans_q    <= 1'b0;
      func_q       <= hngm_pkg::FN_PUT;
      name_q       <= '0;
      len_q        <= '0;
      cell_q       <= '0;
      kind_q       <= '0;
      pres_q       <= 1'b0;
      status_q     <= hngm_pkg::ST_OK;
      ins_q        <= 1'b0;
      ans_q        <= 1'b0;
      slot_q       <= '0;
      cnt_q        <= '0;
      byte_q       <= '0;
      sweep_q      <= '0;
      base_q       <= '0;
      crc_q        <= '1;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == hngm_pkg::CFG_WIDTH) width_q <= cfg_data_i;
        else height_q <= cfg_data_i;
      end
      // a finished item reloads the output register in S_DONE
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            func_q   <= hngm_pkg::func_e'(in_func_i);
            name_q   <= name_c;
            len_q    <= len_c;
            cell_q   <= cell_c;
            kind_q   <= in_kind_value_i;
            pres_q   <= in_present_value_i;
            status_q <= hngm_pkg::ST_OK;
            slot_q   <= '0;
            ins_q    <= 1'b0;
            ans_q    <= 1'b0;
            crc_q    <= '1;
            byte_q   <= '0;
            cnt_q    <= '0;
            case (in_func_i)
              hngm_pkg::FN_PUT: state_q <= S_CRC;
              hngm_pkg::FN_KIND, hngm_pkg::FN_PRESENT, hngm_pkg::FN_READ: begin
                if (inb_c) state_q <= S_CRC;
                else begin
                  status_q <= hngm_pkg::ST_BOUNDS;
                  state_q  <= S_DONE;
                end
              end
              hngm_pkg::FN_PREFIX: begin
                if (inb_c) state_q <= S_SCAN_RD;
                else begin
                  status_q <= hngm_pkg::ST_BOUNDS;
                  state_q  <= S_DONE;
                end
              end
              hngm_pkg::FN_CLEAR: begin
                used_q  <= '0;
                state_q <= S_DONE;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_CRC: begin
          if (byte_q == len_q) begin
            base_q  <= crc_fin[hngm_pkg::SLOT_W-1:0];
            state_q <= S_PRB_RD;
          end else begin
            crc_q  <= hngm_pkg::crc_byte(crc_q, name_q[{byte_q, 3'b000} +: 8]);
            byte_q <= byte_q + 1'b1;
          end
        end
        S_PRB_RD: begin
          if (!used_q[probe_s]) begin
            if (func_q == hngm_pkg::FN_PUT) begin
              used_q[probe_s] <= 1'b1;
              slot_q  <= probe_s;
              ins_q   <= 1'b1;
              sweep_q <= '0;
              state_q <= S_CLR;
            end else begin
              status_q <= hngm_pkg::ST_NOTFOUND;
              state_q  <= S_DONE;
            end
          end else begin
            state_q <= S_PRB_CMP;
          end
        end
        S_PRB_CMP: begin
          if (key_match) begin
            slot_q  <= probe_s;
            state_q <= (func_q == hngm_pkg::FN_PUT) ? S_DONE : S_CELL_RD;
          end else if (cnt_q == hngm_pkg::SLOT_W'(hngm_pkg::SLOTS - 1)) begin
            status_q <= (func_q == hngm_pkg::FN_PUT) ? hngm_pkg::ST_FULL
                                                      : hngm_pkg::ST_NOTFOUND;
            state_q  <= S_DONE;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_PRB_RD;
          end
        end
        S_CLR: begin
          sweep_q <= sweep_q + 1'b1;
          if (sweep_q == '1) state_q <= S_DONE;
        end
        S_CELL_RD: state_q <= S_CELL_WR;
        S_CELL_WR: begin
          if (func_q == hngm_pkg::FN_READ) ans_q <= cell_rd_q.present;
          state_q <= S_DONE;
        end
        S_SCAN_RD: begin
          if (used_q[cnt_q]) state_q <= S_SCAN_CMP;
          else if (cnt_q == hngm_pkg::SLOT_W'(hngm_pkg::SLOTS - 1)) state_q <= S_DONE;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_SCAN_CMP: begin
          if (pfx_hit) begin
            ans_q   <= 1'b1;
            state_q <= S_DONE;
          end else if (cnt_q == hngm_pkg::SLOT_W'(hngm_pkg::SLOTS - 1)) begin
            state_q <= S_DONE;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_slot_q   <= 4'(slot_q);
            out_ins_q    <= ins_q;
            out_ans_q    <= ans_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign out_status_o   = out_status_q;
  assign out_slot_o     = out_slot_q;
  assign out_inserted_o = out_ins_q;
  assign out_answer_o   = out_ans_q;

`ifndef SYNTHESIS
  a_ins_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_inserted_o |-> out_status_o == hngm_pkg::ST_OK)
    else $error("insert reported with error status");
  a_ans_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_answer_o |-> out_status_o == hngm_pkg::ST_OK)
    else $error("answer set with error status");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_status_o) &&
    $stable(out_slot_o) && $stable(out_inserted_o) && $stable(out_answer_o))
    else $error("stalled result changed");
  a_crc_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CRC |-> byte_q <= len_q)
    else $error("hash byte counter ran past name length");
`endif

endmodule
